### hdl/eti_pkg.sv
// Shared constants for the equation-of-state table interpolator.
`default_nettype none
package eti_pkg;
    localparam int TABLE_ROWS_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int ROWS_W         = 13;

    // request types
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_ENERGY  = 2'd1;
    localparam logic [1:0] REQ_ENTROPY = 2'd2;
    localparam logic [1:0] REQ_SKIP    = 2'd3;  // ignored, no result

    // range status codes
    localparam logic [1:0] STAT_IN    = 2'd0;
    localparam logic [1:0] STAT_BELOW = 2'd1;
    localparam logic [1:0] STAT_ABOVE = 2'd2;

    // register indexes
    localparam logic [1:0] REG_GRID_START = 2'd0;
    localparam logic [1:0] REG_INV_STEP   = 2'd1;
    localparam logic [1:0] REG_ROWS_USED  = 2'd2;
endpackage
`default_nettype wire

### hdl/eti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module eti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/eos_table_interpolator.sv
// Top level: equation-of-state table with energy and entropy interpolation.
// A write item stores one row (energy, pressure, entropy, temperature) in four
// column RAMs and returns no result. An energy query does one multiply for
// the grid index, two row reads, a bit-serial fraction divide of FRAC_BITS
// steps and two blends, each a low-side multiply and a high-side
// multiply-add. An entropy query reads the first and last rows, then scans
// the entropy column one row per cycle from row 1 until the interval holding
// the key is found; clamped queries finish after the end reads.
// The block takes one item at a time; a finished result waits in the output
// register while the next item is accepted. No clearing pass follows reset.
`default_nettype none
module eos_table_interpolator #(
    parameter int TABLE_ROWS = eti_pkg::TABLE_ROWS_DEF,
    parameter int FRAC_BITS  = eti_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_row_index,
    input  wire logic [31:0] i_energy_val,
    input  wire logic [31:0] i_pressure_val,
    input  wire logic [31:0] i_entropy_val,
    input  wire logic [31:0] i_temperature_val,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_temperature_out,
    output logic      [31:0] o_pressure_out,
    output logic      [31:0] o_energy_out,
    output logic      [1:0]  o_range_status
);
    localparam int DW  = eti_pkg::DATA_W;
    localparam int AW  = $clog2(TABLE_ROWS);
    localparam int NW  = $clog2(TABLE_ROWS + 1);
    localparam int FW  = FRAC_BITS + 1;
    localparam int MW  = DW + FW;
    localparam int ACW = MW + 1;
    localparam int CW  = $clog2(FRAC_BITS + 1);
    localparam logic [FW-1:0] UNIT = FW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_E_MUL, S_E_IDX, S_E_RD0, S_E_RD1,
        S_S_ADR, S_S_RD0, S_S_RD1, S_SCAN,
        S_FRAC, S_DIV, S_BL0, S_BL1, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DW-1:0]              r_grid_start;
    logic [DW-1:0]              r_inv_step;
    logic [eti_pkg::ROWS_W-1:0] r_rows_used;
    logic                       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_start <= '0;
            r_inv_step   <= DW'(65536);
            r_rows_used  <= eti_pkg::ROWS_W'(4096);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                eti_pkg::REG_GRID_START: r_grid_start <= pwdata;
                eti_pkg::REG_INV_STEP:   r_inv_step   <= pwdata;
                eti_pkg::REG_ROWS_USED:  r_rows_used  <= pwdata[eti_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            eti_pkg::REG_GRID_START: prdata = r_grid_start;
            eti_pkg::REG_INV_STEP:   prdata = r_inv_step;
            eti_pkg::REG_ROWS_USED:  prdata = 32'(r_rows_used);
            default:                 prdata = '0;
        endcase
    end

    // active row count, clamped to 2..TABLE_ROWS
    logic [NW-1:0] w_rows;
    logic [AW-1:0] w_last;
    always_comb begin
        if (r_rows_used < eti_pkg::ROWS_W'(2)) begin
            w_rows = NW'(2);
        end else if (32'(r_rows_used) > 32'(TABLE_ROWS)) begin
            w_rows = NW'(TABLE_ROWS);
        end else begin
            w_rows = NW'(r_rows_used);
        end
        w_last = AW'(w_rows - NW'(1));
    end

    // input accept and row write
    logic w_accept;
    logic w_we;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_we       = w_accept && (i_req_type == eti_pkg::REQ_WRITE)
                        && (32'(i_row_index) < 32'(TABLE_ROWS));

    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rd_e, w_rd_p, w_rd_s, w_rd_t;
    assign w_waddr = AW'(32'(i_row_index));

    eti_ram #(.WIDTH(DW), .DEPTH(TABLE_ROWS)) u_energy (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_energy_val),
        .i_raddr(w_raddr), .o_rdata(w_rd_e)
    );
    eti_ram #(.WIDTH(DW), .DEPTH(TABLE_ROWS)) u_pressure (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_pressure_val),
        .i_raddr(w_raddr), .o_rdata(w_rd_p)
    );
    eti_ram #(.WIDTH(DW), .DEPTH(TABLE_ROWS)) u_entropy (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_entropy_val),
        .i_raddr(w_raddr), .o_rdata(w_rd_s)
    );
    eti_ram #(.WIDTH(DW), .DEPTH(TABLE_ROWS)) u_temperature (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_temperature_val),
        .i_raddr(w_raddr), .o_rdata(w_rd_t)
    );

    // working registers
    logic          r_is_energy;
    logic [DW-1:0] r_key;
    logic [63:0]   r_prod;
    logic          r_below;
    logic [1:0]    r_stat;
    logic [AW-1:0] r_i;
    logic [DW-1:0] r_e0;
    logic [DW-1:0] r_lok, r_hik;
    logic [DW-1:0] r_lo_a, r_hi_a, r_lo_b, r_hi_b;
    logic [DW-1:0] r_rem, r_den;
    logic [FRAC_BITS-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic [FW-1:0] r_f;
    logic [ACW-1:0] r_acc;
    logic          r_phase;
    logic [DW-1:0] r_res_a, r_res_b;

    // grid index
    logic [63:0] w_idx;
    logic [63:0] w_lastx;
    assign w_idx   = r_prod >> (2 * FRAC_BITS);
    assign w_lastx = 64'(w_last);

    // fraction setup
    logic [DW-1:0] w_num, w_den;
    assign w_num = r_key - r_lok;
    assign w_den = (r_hik > r_lok) ? (r_hik - r_lok) : '0;

    // one restoring divide step
    logic [DW:0]          w_rem2;
    logic                 w_qbit;
    logic [FRAC_BITS-1:0] w_q_next;
    assign w_rem2   = {r_rem, 1'b0};
    assign w_qbit   = (w_rem2 >= {1'b0, r_den});
    assign w_q_next = {r_q[FRAC_BITS-2:0], w_qbit};

    // blend multiplier operands
    logic [DW-1:0]  w_lo_sel, w_hi_sel;
    logic [MW-1:0]  w_mul_lo, w_mul_hi;
    logic [ACW-1:0] w_sum;
    logic [DW-1:0]  w_blend;
    assign w_lo_sel = r_phase ? r_lo_b : r_lo_a;
    assign w_hi_sel = r_phase ? r_hi_b : r_hi_a;
    assign w_mul_lo = MW'(w_lo_sel) * MW'(UNIT - r_f);
    assign w_mul_hi = MW'(w_hi_sel) * MW'(r_f);
    assign w_sum    = r_acc + ACW'(w_mul_hi);
    assign w_blend  = w_sum[FRAC_BITS +: DW];

    // read address per state
    always_comb begin
        case (r_state)
            S_E_IDX: begin
                if (r_below) begin
                    w_raddr = '0;
                end else if (w_idx >= w_lastx) begin
                    w_raddr = w_last;
                end else begin
                    w_raddr = AW'(w_idx);
                end
            end
            S_E_RD0: w_raddr = r_i + AW'(1);
            S_S_ADR: w_raddr = '0;
            S_S_RD0: w_raddr = w_last;
            S_S_RD1: w_raddr = AW'(1);
            S_SCAN:  w_raddr = r_i + AW'(1);
            default: w_raddr = '0;
        endcase
    end

    logic w_out_free;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_is_energy <= (i_req_type == eti_pkg::REQ_ENERGY);
                        r_key <= (i_req_type == eti_pkg::REQ_ENERGY) ? i_energy_val
                                                                      : i_entropy_val;
                        r_phase <= 1'b0;
                        case (i_req_type)
                            eti_pkg::REQ_ENERGY:  r_state <= S_E_MUL;
                            eti_pkg::REQ_ENTROPY: r_state <= S_S_ADR;
                            default:              r_state <= S_IDLE;
                        endcase
                    end
                end
                S_E_MUL: begin
                    r_prod  <= 64'(r_key - r_grid_start) * 64'(r_inv_step);
                    r_below <= (r_key <= r_grid_start);
                    r_state <= S_E_IDX;
                end
                S_E_IDX: begin
                    if (r_below) begin
                        r_stat <= eti_pkg::STAT_BELOW;
                    end else if (w_idx >= w_lastx) begin
                        r_stat <= eti_pkg::STAT_ABOVE;
                    end else begin
                        r_stat <= eti_pkg::STAT_IN;
                        r_i    <= AW'(w_idx);
                    end
                    r_state <= S_E_RD0;
                end
                S_E_RD0: begin
                    if (r_stat != eti_pkg::STAT_IN) begin
                        r_res_a <= w_rd_t;
                        r_res_b <= w_rd_p;
                        r_state <= S_OUT;
                    end else begin
                        r_lok   <= w_rd_e;
                        r_lo_a  <= w_rd_t;
                        r_lo_b  <= w_rd_p;
                        r_state <= S_E_RD1;
                    end
                end
                S_E_RD1: begin
                    r_hik   <= w_rd_e;
                    r_hi_a  <= w_rd_t;
                    r_hi_b  <= w_rd_p;
                    r_state <= S_FRAC;
                end
                S_S_ADR: r_state <= S_S_RD0;
                S_S_RD0: begin
                    r_e0    <= w_rd_e;
                    r_lok   <= w_rd_s;
                    r_state <= S_S_RD1;
                end
                S_S_RD1: begin
                    if (r_key < r_lok) begin
                        r_res_a <= r_e0;
                        r_stat  <= eti_pkg::STAT_BELOW;
                        r_state <= S_OUT;
                    end else if (r_key >= w_rd_s) begin
                        r_res_a <= w_rd_e;
                        r_stat  <= eti_pkg::STAT_ABOVE;
                        r_state <= S_OUT;
                    end else begin
                        r_lo_a  <= r_e0;
                        r_stat  <= eti_pkg::STAT_IN;
                        r_i     <= AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // row r_i arrives; check interval (r_i-1, r_i)
                    if (r_lok <= r_key && r_key < w_rd_s) begin
                        r_hik   <= w_rd_s;
                        r_hi_a  <= w_rd_e;
                        r_state <= S_FRAC;
                    end else if (r_i == w_last) begin
                        r_res_a <= r_e0;
                        r_state <= S_OUT;
                    end else begin
                        r_lok  <= w_rd_s;
                        r_lo_a <= w_rd_e;
                        r_i    <= r_i + AW'(1);
                    end
                end
                S_FRAC: begin
                    if (r_key <= r_lok) begin
                        r_f     <= '0;
                        r_state <= S_BL0;
                    end else if (w_num >= w_den) begin
                        r_f     <= UNIT;
                        r_state <= S_BL0;
                    end else begin
                        r_rem   <= w_num;
                        r_den   <= w_den;
                        r_q     <= '0;
                        r_cnt   <= CW'(FRAC_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_qbit ? DW'(w_rem2 - {1'b0, r_den}) : DW'(w_rem2);
                    r_q   <= w_q_next;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_f     <= {1'b0, w_q_next};
                        r_state <= S_BL0;
                    end
                end
                S_BL0: begin
                    r_acc   <= ACW'(w_mul_lo);
                    r_state <= S_BL1;
                end
                S_BL1: begin
                    if (!r_phase) begin
                        r_res_a <= w_blend;
                    end else begin
                        r_res_b <= w_blend;
                    end
                    if (r_is_energy && !r_phase) begin
                        r_phase <= 1'b1;
                        r_state <= S_BL0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_out_valid       <= 1'b1;
                        o_temperature_out <= r_is_energy ? r_res_a : '0;
                        o_pressure_out    <= r_is_energy ? r_res_b : '0;
                        o_energy_out      <= r_is_energy ? '0 : r_res_a;
                        o_range_status    <= r_stat;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
